// File: hw/rtl/utf8vf_pkg.sv
// ============================================================================
// utf8vf_pkg
// Shared types, byte codes and the letter fold function.
// ============================================================================
package utf8vf_pkg;

    // UTF-8 lead bytes that can start a Vietnamese letter
    localparam logic [7:0] LEAD_C3 = 8'hC3;
    localparam logic [7:0] LEAD_C6 = 8'hC6;
    localparam logic [7:0] LEAD_E1 = 8'hE1;
    // second bytes of the U+1EA0..U+1EF9 block
    localparam logic [7:0] MID_BA  = 8'hBA;
    localparam logic [7:0] MID_BB  = 8'hBB;
    // continuation byte range
    localparam logic [7:0] CONT_LO = 8'h80;
    localparam logic [7:0] CONT_HI = 8'hBF;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_U = 8'h55;
    localparam logic [7:0] CH_Y = 8'h59;
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam int MaxRes = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]                cnt;   // 0..3 result bytes
        logic [MaxRes-1:0][7:0]    bytes; // in output order, index 0 first
    } t_step_res;

    function automatic logic is_cont(input logic [7:0] b);
        return (b >= CONT_LO) && (b <= CONT_HI);
    endfunction

    function automatic logic is_lead(input logic [7:0] b);
        return ((b >= LEAD_C3) && (b <= LEAD_C6)) || (b == LEAD_E1);
    endfunction

    // ASCII letter for a code point, 0 when it is not a folded letter
    function automatic logic [7:0] fold_cp(input logic [15:0] cp);
        logic [7:0] up;
        logic       lower;
        logic [7:0] c;
        up    = 8'h00;
        lower = 1'b0;
        c     = cp[7:0] & 8'hDF;
        if ((cp >= 16'h1EA0) && (cp <= 16'h1EF9)) begin
            if (cp <= 16'h1EB7)      up = CH_A;
            else if (cp <= 16'h1EC7) up = CH_E;
            else if (cp <= 16'h1ECB) up = CH_I;
            else if (cp <= 16'h1EE3) up = CH_O;
            else if (cp <= 16'h1EF1) up = CH_U;
            else                     up = CH_Y;
            lower = cp[0];
        end else if ((cp >= 16'h00C0) && (cp <= 16'h00FF)) begin
            lower = cp[5];
            if ((c >= 8'hC0) && (c <= 8'hC3))      up = CH_A;
            else if ((c >= 8'hC8) && (c <= 8'hCA)) up = CH_E;
            else if ((c == 8'hCC) || (c == 8'hCD)) up = CH_I;
            else if ((c >= 8'hD2) && (c <= 8'hD5)) up = CH_O;
            else if ((c == 8'hD9) || (c == 8'hDA)) up = CH_U;
            else if (c == 8'hDD)                   up = CH_Y;
        end else begin
            case (cp)
                16'h0102: up = CH_A;
                16'h0103: begin up = CH_A; lower = 1'b1; end
                16'h0110: up = CH_D;
                16'h0111: begin up = CH_D; lower = 1'b1; end
                16'h0128: up = CH_I;
                16'h0129: begin up = CH_I; lower = 1'b1; end
                16'h0168: up = CH_U;
                16'h0169: begin up = CH_U; lower = 1'b1; end
                16'h01A0: up = CH_O;
                16'h01A1: begin up = CH_O; lower = 1'b1; end
                16'h01AF: up = CH_U;
                16'h01B0: begin up = CH_U; lower = 1'b1; end
                default:  up = 8'h00;
            endcase
        end
        if (up == 8'h00) return 8'h00;
        return lower ? (up | CASE_BIT) : up;
    endfunction

endpackage

// File: hw/rtl/utf8_vietnamese_to_ascii_folder_core.sv
// ============================================================================
// utf8_vietnamese_to_ascii_folder_core
// Folds precomposed Vietnamese letters in a UTF-8 byte stream to ASCII.
// ============================================================================
// Usage:
//   Slave stream: one UTF-8 byte per beat in tdata; tlast marks the final
//   byte of a text, after which any held lead bytes are flushed.
//   Master stream: result bytes in tdata; tlast is set on the last result
//   byte caused by an input beat. An input beat may cause zero (lead byte
//   held), one, two or three result beats.
//   Path: an accepted beat passes the input register, then the result
//   register, before its first result appears.
//   Throughput: one input beat per cycle while m_tready is high and each
//   beat makes at most one result; one with more holds the result register
//   until all are sent, so the output port, one byte per cycle, sets the rate.
//   Stall: when the master side stalls, the result register holds; the
//   input register and its skid entry absorb up to two more beats, then
//   s_tready drops. s_tready is a flop, not a path from m_tready.
//   Reset (i_rst_n low, synchronous): clears held bytes, pending results
//   and both input entries; no clearing pass is needed.
// ============================================================================
module utf8_vietnamese_to_ascii_folder_core
    import utf8vf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // slave side
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // end_of_text
    // master side
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast    // last_of_run
);

    t_in_beat  s_beat;
    t_in_beat  st_beat;
    logic      st_valid;
    logic      q_free;
    logic      fire;
    t_step_res res;

    assign s_beat.data = i_s_tdata;
    assign s_beat.eot  = i_s_tlast;

    // a step runs when a beat is registered and the result register drains
    assign fire = st_valid && q_free;

    utf8vf_in_skid u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_beat  (s_beat),
        .o_ready (o_s_tready),
        .i_take  (fire),
        .o_valid (st_valid),
        .o_beat  (st_beat)
    );

    utf8vf_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_beat  (st_beat),
        .o_res   (res)
    );

    utf8vf_out_queue u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_res    (res),
        .o_free   (q_free),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

endmodule

// File: hw/rtl/utf8vf_in_skid.sv
// ============================================================================
// utf8vf_in_skid
// Input register with a skid entry; ready is a flop, cut from downstream.
// ============================================================================
module utf8vf_in_skid
    import utf8vf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_beat i_beat,
    output logic     o_ready,
    input  logic     i_take,     // stage consumes the held beat
    output logic     o_valid,
    output t_in_beat o_beat
);

    logic     r_main_valid;
    logic     r_skid_valid;
    t_in_beat r_main;
    t_in_beat r_skid;
    logic     acc;

    assign o_ready = !r_skid_valid;
    assign acc     = i_valid && !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_beat  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_take) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= acc;
            end
        end else if (!r_main_valid) begin
            r_main_valid <= acc;
        end else if (acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_main <= r_skid_valid ? r_skid : i_beat;
        end else if (!r_main_valid) begin
            r_main <= i_beat;
        end else if (acc) begin
            r_skid <= i_beat;
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry holds a beat while main entry is empty");

endmodule

// File: hw/rtl/utf8vf_fold.sv
// ============================================================================
// utf8vf_fold
// Held-byte state and one-step match: gives up to three result bytes.
// ============================================================================
module utf8vf_fold
    import utf8vf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_beat  i_beat,
    output t_step_res o_res
);

    logic [7:0] r_h0, r_h1;
    logic [1:0] r_cnt;
    logic [7:0] n_h0, n_h1;
    logic [1:0] n_cnt;

    logic [7:0]  b;
    logic [15:0] cp;
    logic [7:0]  f;
    logic        hit;
    logic        e1_mid;
    logic [1:0]  k;

    assign b = i_beat.data;

    // code point candidate for the held lead bytes plus this byte
    always_comb begin
        if (r_cnt == 2'd2) cp = {r_h0[3:0], r_h1[5:0], b[5:0]};
        else               cp = {5'd0, r_h0[4:0], b[5:0]};
    end

    assign f      = fold_cp(cp);
    assign e1_mid = (r_cnt == 2'd1) && (r_h0 == LEAD_E1) && ((b == MID_BA) || (b == MID_BB));
    assign hit    = ((r_cnt == 2'd2) || ((r_cnt == 2'd1) && (r_h0 != LEAD_E1)))
                    && is_cont(b) && (f != 8'h00);

    always_comb begin
        o_res.cnt   = 2'd0;
        o_res.bytes = '0;
        k     = 2'd0;
        n_h0  = r_h0;
        n_h1  = r_h1;
        n_cnt = 2'd0;
        if (e1_mid) begin
            n_h1  = b;
            n_cnt = 2'd2;
        end else if (hit) begin
            o_res.bytes[k] = f;
            k = k + 2'd1;
        end else begin
            // mismatch: held bytes out in order (count of 3 means none)
            if ((r_cnt == 2'd1) || (r_cnt == 2'd2)) begin
                o_res.bytes[k] = r_h0;
                k = k + 2'd1;
            end
            if (r_cnt == 2'd2) begin
                o_res.bytes[k] = r_h1;
                k = k + 2'd1;
            end
            if (is_lead(b)) begin
                n_h0  = b;
                n_cnt = 2'd1;
            end else begin
                o_res.bytes[k] = b;
                k = k + 2'd1;
            end
        end
        if (i_beat.eot) begin
            if (n_cnt != 2'd0) begin
                o_res.bytes[k] = n_h0;
                k = k + 2'd1;
            end
            if (n_cnt == 2'd2) begin
                o_res.bytes[k] = n_h1;
                k = k + 2'd1;
            end
            n_cnt = 2'd0;
        end
        o_res.cnt = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_h0  <= 8'h00;
            r_h1  <= 8'h00;
        end else if (i_fire) begin
            r_cnt <= n_cnt;
            r_h0  <= n_h0;
            r_h1  <= n_h1;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("held byte count reached three");

    a_pair_starts_e1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (r_h0 == LEAD_E1))
        else $error("two held bytes without E1 lead");

endmodule

// File: hw/rtl/utf8vf_out_queue.sv
// ============================================================================
// utf8vf_out_queue
// Result register: holds one step's bytes and sends them out one per beat.
// ============================================================================
module utf8vf_out_queue
    import utf8vf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_step_res i_res,
    output logic      o_free,    // may load at this edge
    output logic      o_tvalid,
    input  logic      i_tready,
    output logic [7:0] o_tdata,
    output logic      o_tlast
);

    logic [MaxRes-1:0][7:0] r_q;
    logic [1:0] r_cnt;
    logic [1:0] r_rd;
    logic       pop;

    assign o_tvalid = (r_rd != r_cnt);
    assign o_tlast  = ((r_rd + 2'd1) == r_cnt);
    assign o_tdata  = r_q[r_rd];
    assign pop      = o_tvalid && i_tready;
    assign o_free   = !o_tvalid || (pop && o_tlast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_res.cnt;
            r_rd  <= 2'd0;
        end else if (pop) begin
            r_rd  <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_q <= i_res.bytes;
    end

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd <= r_cnt)
        else $error("read index past result count");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result register overwritten before drained");

endmodule

// File: test/utf8_fold_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// utf8_fold_checker
// Watches both streams of the Vietnamese folder core. It predicts the
// result beats of every accepted input beat and compares them in order.
// ============================================================================
module utf8_fold_checker
    import utf8vf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // end_of_text
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [7:0] out_byte
    input  logic       i_m_tlast,   // last_of_run
    output int         o_fail_count,
    output int         o_pending,
    output int         o_out_beats,
    output int         o_folded
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_out_char;

    t_out_char  expected_out[$];
    logic [7:0] held_lead [2];
    logic [1:0] held_n;
    int         fail_count;
    int         out_beats;
    int         folded;

    // base letter of a code point, 0 when the code point is not folded
    function automatic logic [7:0] ascii_letter(input logic [15:0] cp);
        logic [7:0] base;
        logic       lower;
        base  = 8'h00;
        lower = 1'b0;
        if (cp >= 16'h1EA0 && cp <= 16'h1EF9) begin
            lower = cp[0];
            base  = (cp <= 16'h1EB7) ? "A" :
                    (cp <= 16'h1EC7) ? "E" :
                    (cp <= 16'h1ECB) ? "I" :
                    (cp <= 16'h1EE3) ? "O" :
                    (cp <= 16'h1EF1) ? "U" : "Y";
        end else if (cp[15:8] == 8'h00 && cp[7:6] == 2'b11) begin
            // Latin-1 letters; bit 5 is the case, low five bits the letter
            lower = cp[5];
            case (cp[4:0])
                5'h00, 5'h01, 5'h02, 5'h03: base = "A";
                5'h08, 5'h09, 5'h0A:        base = "E";
                5'h0C, 5'h0D:               base = "I";
                5'h12, 5'h13, 5'h14, 5'h15: base = "O";
                5'h19, 5'h1A:               base = "U";
                5'h1D:                      base = "Y";
                default:                    base = 8'h00;
            endcase
        end else begin
            lower = cp[0];
            case (cp)
                16'h0102, 16'h0103: base = "A";
                16'h0110, 16'h0111: base = "D";
                16'h0128, 16'h0129: base = "I";
                16'h0168, 16'h0169: base = "U";
                16'h01A0, 16'h01A1: base = "O";
                16'h01AF:           begin base = "U"; lower = 1'b0; end
                16'h01B0:           begin base = "U"; lower = 1'b1; end
                default:            base = 8'h00;
            endcase
        end
        if (base == 8'h00) return 8'h00;
        return lower ? base + 8'h20 : base;
    endfunction

    // advance the held-lead state by one text byte, queue what it releases
    task automatic predict_beat(input logic [7:0] b, input logic eot);
        logic [7:0] res [3];
        int         n;
        int         i;
        logic [7:0] letter;
        logic       taken;
        logic       cont;
        t_out_char  item;
        n      = 0;
        letter = 8'h00;
        taken  = 1'b0;
        cont   = (b >= CONT_LO) && (b <= CONT_HI);
        case (held_n)
            2'd1: begin
                if (held_lead[0] == LEAD_E1) begin
                    if (b == MID_BA || b == MID_BB) begin
                        held_lead[1] = b;
                        held_n       = 2'd2;
                        taken        = 1'b1;
                    end
                end else if (cont) begin
                    letter = ascii_letter({5'd0, held_lead[0][4:0], b[5:0]});
                end
            end
            2'd2: begin
                if (cont)
                    letter = ascii_letter({held_lead[0][3:0], held_lead[1][5:0], b[5:0]});
            end
            default: held_n = 2'd0;  // a count of three never occurs; read as empty
        endcase
        if (letter != 8'h00) begin
            res[n] = letter;
            n++;
            held_n = 2'd0;
            folded++;
        end else if (!taken) begin
            // mismatch: release held leads, then treat b as a fresh start
            for (i = 0; i < held_n; i++) begin
                res[n] = held_lead[i];
                n++;
            end
            held_n = 2'd0;
            if ((b >= LEAD_C3 && b <= LEAD_C6) || b == LEAD_E1) begin
                held_lead[0] = b;
                held_n       = 2'd1;
            end else begin
                res[n] = b;
                n++;
            end
        end
        if (eot) begin
            for (i = 0; i < held_n; i++) begin
                res[n] = held_lead[i];
                n++;
            end
            held_n = 2'd0;
        end
        for (i = 0; i < n; i++) begin
            item.ch   = res[i];
            item.last = (i == n - 1);
            expected_out.push_back(item);
        end
    endtask

    task automatic note_mismatch(input string what, input t_out_char want);
        if (fail_count < 10)
            $display("%0t: beat %0d %s: expected %02h last=%0b, got %02h last=%0b",
                     $realtime, out_beats, what, want.ch, want.last, i_m_tdata, i_m_tlast);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_char want;
        if (!i_rst_n) begin
            expected_out.delete();
            held_lead[0] = 8'h00;
            held_lead[1] = 8'h00;
            held_n       = 2'd0;
        end else begin
            // compare first: a beat leaving now cannot stem from one entering now
            if (i_m_tvalid && i_m_tready) begin
                if (expected_out.size() == 0) begin
                    want = '0;
                    note_mismatch("arrived with nothing expected", want);
                end else begin
                    want = expected_out.pop_front();
                    if (want.ch !== i_m_tdata || want.last !== i_m_tlast)
                        note_mismatch("differs", want);
                end
                out_beats++;
            end
            if (i_s_tvalid && i_s_tready)
                predict_beat(i_s_tdata, i_s_tlast);
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_out.size();
        o_out_beats  <= out_beats;
        o_folded     <= folded;
    end

endmodule

// File: test/tb_utf8_vietnamese_to_ascii_folder_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_utf8_vietnamese_to_ascii_folder_core
// Drives UTF-8 text through the folder core: a directed set of letters,
// mismatches and flushes, then random Vietnamese-like text with noise and
// broken sequences. A side checker predicts and compares every result beat.
// ============================================================================
module tb_utf8_vietnamese_to_ascii_folder_core;
    import utf8vf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;  // watchdog, far above the slowest run
    localparam int HOLD_CYCLES  = 100;     // long receiver hold-off
    localparam int RANDOM_BEATS = 85;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int fail_count;
    int pending;
    int out_beats;
    int folded;
    int sent_beats  = 0;
    int text_ends   = 0;
    int holds_done  = 0;
    int cycle_count = 0;
    bit calm        = 1'b0;  // no idling on either side while set

    utf8_vietnamese_to_ascii_folder_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // [7:0] in_byte
        .i_s_tlast  (s_tlast),   // end_of_text
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // [7:0] out_byte
        .o_m_tlast  (m_tlast)    // last_of_run
    );

    utf8_fold_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_out_beats  (out_beats),
        .o_folded     (folded)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, pending);
            $display("simulation failed");
            $finish;
        end
    end

    // idle cycles before an input beat: mostly none, some short, a few long
    function automatic int next_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    function automatic logic coin_eot();
        return ($urandom_range(0, 99) < 8);
    endfunction

    // the Latin Extended letters the core folds
    function automatic logic [15:0] ext_letter(input int k);
        case (k)
            0:       return 16'h0102;
            1:       return 16'h0103;
            2:       return 16'h0110;  // D stroke
            3:       return 16'h0111;  // d stroke
            4:       return 16'h0128;
            5:       return 16'h0129;
            6:       return 16'h0168;
            7:       return 16'h0169;
            8:       return 16'h01A0;
            9:       return 16'h01A1;  // o horn
            10:      return 16'h01AF;
            default: return 16'h01B0;  // u horn
        endcase
    endfunction

    // one beat on the slave side; returns at the edge that takes it
    task automatic send_beat(input logic [7:0] b, input logic eot);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do @(posedge clk); while (!s_tready);
        sent_beats++;
        if (eot) text_ends++;
    endtask

    // one random unit of text: mostly well-formed letters, some noise
    task automatic send_random_unit();
        int          kind;
        logic [15:0] cp;
        logic [7:0]  lead;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            send_beat(8'($urandom_range(0, 127)), coin_eot());
        end else if (kind < 55) begin
            // two-byte letter; the wider ranges also hit non-folding code points
            case ($urandom_range(0, 3))
                0, 1:    cp = 16'($urandom_range(16'h00C0, 16'h00FF));
                2:       cp = ext_letter($urandom_range(0, 11));
                default: cp = 16'($urandom_range(16'h0100, 16'h01BF));
            endcase
            send_beat(8'hC0 | cp[10:6], 1'b0);
            send_beat(8'h80 | cp[5:0], coin_eot());
        end else if (kind < 80) begin
            cp = 16'($urandom_range(16'h1E80, 16'h1EFF));
            send_beat(LEAD_E1, 1'b0);
            send_beat(8'h80 | cp[11:6], 1'b0);
            send_beat(8'h80 | cp[5:0], coin_eot());
        end else if (kind < 90) begin
            send_beat(8'($urandom_range(0, 255)), coin_eot());
        end else begin
            lead = ($urandom_range(0, 4) == 0) ? LEAD_E1
                                               : 8'(LEAD_C3 + $urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: send_beat(lead, 1'b1);  // lead cut off by end of text
                1: begin
                    send_beat(lead, 1'b0);
                    send_beat(8'($urandom_range(0, 255)), coin_eot());
                end
                2: begin
                    // three-byte prefix with a bad final byte
                    send_beat(LEAD_E1, 1'b0);
                    send_beat($urandom_range(0, 1) ? MID_BB : MID_BA, 1'b0);
                    send_beat($urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                                   : 8'($urandom_range(192, 255)),
                              coin_eot());
                end
                default: begin
                    // two held bytes flushed by end of text
                    send_beat(LEAD_E1, 1'b0);
                    send_beat($urandom_range(0, 1) ? MID_BB : MID_BA, 1'b1);
                end
            endcase
        end
    endtask

    // receiver: random stalls, calm stretch, and two long hold-offs
    initial begin
        int r;
        int len;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if ((sent_beats >= 30 && holds_done == 0) ||
                (sent_beats >= 95 && holds_done == 1)) begin
                // sender keeps offering; the core fills up and drops s_tready
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end else if (calm) begin
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    len = (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 25);
                    repeat (len - 1) @(posedge clk);
                end
            end
        end
    end

    // stimulus and verdict
    initial begin
        int random_start;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes pass through
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        // Latin-1: A grave -> A, y acute -> y
        send_beat(LEAD_C3, 1'b0); send_beat(8'h80, 1'b0);
        send_beat(LEAD_C3, 1'b0); send_beat(8'hBD, 1'b0);
        // d stroke -> d, u horn -> u
        send_beat(8'hC4, 1'b0);   send_beat(8'h91, 1'b0);
        send_beat(LEAD_C6, 1'b0); send_beat(8'hB0, 1'b0);
        // three-byte block, both ends: A dot below -> A, y tilde -> y
        send_beat(LEAD_E1, 1'b0); send_beat(MID_BA, 1'b0); send_beat(8'hA0, 1'b0);
        send_beat(LEAD_E1, 1'b0); send_beat(MID_BB, 1'b0); send_beat(8'hB9, 1'b0);
        // mismatch on plain ASCII
        send_beat(LEAD_C3, 1'b0); send_beat(8'h41, 1'b0);
        // mismatch where the current byte is held again, then no letter
        send_beat(8'hC5, 1'b0);   send_beat(LEAD_C3, 1'b0); send_beat(8'hBF, 1'b0);
        // bad continuation after a three-byte prefix: three results
        send_beat(LEAD_E1, 1'b0); send_beat(MID_BA, 1'b0); send_beat(8'hC0, 1'b0);
        // lone lead flushed by end of text
        send_beat(LEAD_E1, 1'b1);

        random_start = sent_beats;
        while (sent_beats < random_start + RANDOM_BEATS) begin
            calm = (sent_beats >= random_start + 35) && (sent_beats < random_start + 55);
            send_random_unit();
        end
        calm = 1'b0;
        send_beat(8'h2E, 1'b1);  // close the text so nothing stays held
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d input beats in %0d texts, %0d result beats, %0d letters folded",
                 sent_beats, text_ends, out_beats, folded);
        $display("receiver held off %0d times for %0d cycles with the sender still offering",
                 holds_done, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
